[rtl/bss_pkg.sv]
// Shared types and constants for the bounded substring search block.
`default_nettype none
package bss_pkg;

  localparam int OFFSET_BITS  = 24;
  localparam int LIMIT_BITS   = 24;
  localparam int PLEN_BITS    = 5;
  localparam int CFG_IDX_BITS = 3;
  localparam int CFG_DATA_BITS = 64;
  localparam int PAT_BYTES    = 16;

  localparam logic [CFG_IDX_BITS-1:0] REG_PATTERN_LOW    = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_PATTERN_HIGH   = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_PATTERN_LENGTH = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_LIMIT_ENABLED  = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_SEARCH_LIMIT   = 3'd4;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       restart;
    logic       last_byte;
  } in_req_t;

  typedef struct packed {
    logic                   found;
    logic [OFFSET_BITS-1:0] match_start;
    logic [OFFSET_BITS-1:0] match_end;
  } out_req_t;

  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctl_t;

endpackage
`default_nettype wire

[rtl/bss_cell.sv]
// One history cell: holds one text byte and compares the incoming byte with its pattern byte.
`default_nettype none
module bss_cell (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire bss_pkg::cell_ctl_t  ctl,
  input  wire logic [7:0]          din,
  input  wire logic                vin,
  input  wire logic [7:0]          exp_byte,
  output logic [7:0]               dout,
  output logic                     vout,
  output logic                     hit
);

  logic [7:0] byte_r;
  logic       valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ctl.shift) begin
      valid_r <= vin;
    end else if (ctl.clear) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      byte_r <= din;
    end
  end

  // The compare looks at the byte this cell holds after the shift.
  assign hit  = vin && (din == exp_byte);
  assign dout = byte_r;
  assign vout = valid_r;

endmodule
`default_nettype wire

[rtl/bounded_substring_search_top.sv]
// Bounded substring search: a chain of byte cells matched against a configured pattern.
// A result is registered on the output, visible in the cycle after the request that causes it is taken.
// Throughput: one text byte per cycle; the compare of all cells and the offset update
// finish in the cycle the byte is taken, so the cell chain accepts a byte every cycle.
// Input is held off only while a finished result waits on a stalled output.
// Reset (rst_n low, synchronous) clears config to defaults, history, offset and search state.
`default_nettype none
module bounded_substring_search_top #(
  parameter int PATTERN_MAX = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire bss_pkg::in_req_t                    in_data,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output bss_pkg::out_req_t                        out_data,
  input  wire logic                                cfg_we,
  input  wire logic [bss_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  wire logic [bss_pkg::CFG_DATA_BITS-1:0]   cfg_wdata
);

  localparam int OB    = bss_pkg::OFFSET_BITS;
  localparam int IDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int NW    = $clog2(PATTERN_MAX + 1);
  localparam int NCW   = (NW > bss_pkg::PLEN_BITS) ? NW : bss_pkg::PLEN_BITS;
  localparam int CMPW  = (OB + 1 > bss_pkg::LIMIT_BITS) ? OB + 1 : bss_pkg::LIMIT_BITS;

  // Configuration registers.
  logic [63:0]                      pat_lo_r, pat_hi_r;
  logic [bss_pkg::PLEN_BITS-1:0]    plen_r;
  logic                             lim_en_r;
  logic [bss_pkg::LIMIT_BITS-1:0]   limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_lo_r <= '0;
      pat_hi_r <= '0;
      plen_r   <= bss_pkg::PLEN_BITS'(1);
      lim_en_r <= 1'b0;
      limit_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bss_pkg::REG_PATTERN_LOW:    pat_lo_r <= cfg_wdata[63:0];
        bss_pkg::REG_PATTERN_HIGH:   pat_hi_r <= cfg_wdata[63:0];
        bss_pkg::REG_PATTERN_LENGTH: plen_r   <= cfg_wdata[bss_pkg::PLEN_BITS-1:0];
        bss_pkg::REG_LIMIT_ENABLED:  lim_en_r <= cfg_wdata[0];
        bss_pkg::REG_SEARCH_LIMIT:   limit_r  <= cfg_wdata[bss_pkg::LIMIT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Pattern bytes as a flat vector; bytes past the two pattern registers read as zero.
  logic [PATTERN_MAX*8-1:0] pat_flat;
  for (genvar b = 0; b < PATTERN_MAX; b++) begin : g_pat
    if (b < 8) begin : g_lo
      assign pat_flat[8*b +: 8] = pat_lo_r[8*b +: 8];
    end else if (b < bss_pkg::PAT_BYTES) begin : g_hi
      assign pat_flat[8*b +: 8] = pat_hi_r[8*(b-8) +: 8];
    end else begin : g_zero
      assign pat_flat[8*b +: 8] = 8'd0;
    end
  end

  // Effective pattern length, clamped to 1..PATTERN_MAX.
  logic [NCW-1:0]   plen_x, n_c;
  logic [IDX_W-1:0] n_m1;
  assign plen_x = NCW'(plen_r);
  always_comb begin
    if (plen_x == '0) begin
      n_c = NCW'(1);
    end else if (plen_x > NCW'(PATTERN_MAX)) begin
      n_c = NCW'(PATTERN_MAX);
    end else begin
      n_c = plen_x;
    end
  end
  assign n_m1 = IDX_W'(n_c - NCW'(1));

  // Search state and handshake.
  logic          searching_r, searching_nxt;
  logic [OB-1:0] offset_r, offset_nxt;
  logic          out_valid_r;
  bss_pkg::out_req_t out_r;

  logic acc, active, lim_pre, shift, end_now, all_ok;
  logic emit_found, emit_nf, emit;
  logic [OB-1:0]   pos, pos1;
  logic [CMPW-1:0] pos_x, pos1_x, lim_x;

  assign in_stall = out_valid_r && out_stall;
  assign acc      = in_valid && !in_stall;
  assign active   = in_data.restart || searching_r;
  assign pos      = in_data.restart ? '0 : offset_r;
  assign pos1     = pos + OB'(1);
  assign pos_x    = CMPW'(pos);
  assign pos1_x   = pos_x + CMPW'(1);
  assign lim_x    = CMPW'(limit_r);
  assign lim_pre  = lim_en_r && (pos_x >= lim_x);
  assign shift    = acc && active && !lim_pre;
  assign end_now  = in_data.last_byte || (lim_en_r && (pos1_x >= lim_x));

  // Cell chain, newest byte in cell 0.
  bss_pkg::cell_ctl_t ctl;
  assign ctl.shift = shift;
  assign ctl.clear = acc && in_data.restart;

  logic [7:0]             byt [PATTERN_MAX];
  logic [PATTERN_MAX-1:0] vld, ok;

  for (genvar j = 0; j < PATTERN_MAX; j++) begin : g_cell
    logic [7:0]     din_j, exp_j;
    logic           vin_j, hit_j;
    logic [IDX_W-1:0] idx_j;

    if (j == 0) begin : g_head
      assign din_j = in_data.text_byte;
      assign vin_j = 1'b1;
    end else begin : g_body
      assign din_j = byt[j-1];
      assign vin_j = vld[j-1] && !in_data.restart;
    end

    // Cell j holds the byte that pattern byte (n - 1 - j) must match.
    assign idx_j = n_m1 - IDX_W'(j);
    assign exp_j = ({1'b0, idx_j} < (IDX_W+1)'(PATTERN_MAX)) ?
                   pat_flat[{idx_j, 3'b000} +: 8] : 8'd0;

    bss_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .din      (din_j),
      .vin      (vin_j),
      .exp_byte (exp_j),
      .dout     (byt[j]),
      .vout     (vld[j]),
      .hit      (hit_j)
    );

    assign ok[j] = hit_j || !(NCW'(j) < n_c);
  end

  assign all_ok     = &ok;
  assign emit_found = shift && all_ok;
  assign emit_nf    = (acc && active && lim_pre) || (shift && !all_ok && end_now);
  assign emit       = emit_found || emit_nf;

  always_comb begin
    searching_nxt = searching_r;
    offset_nxt    = offset_r;
    if (acc && in_data.restart) begin
      searching_nxt = 1'b1;
      offset_nxt    = '0;
    end
    if (shift) begin
      offset_nxt = pos1;
    end
    if (emit) begin
      searching_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      searching_r <= 1'b0;
      offset_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      searching_r <= searching_nxt;
      offset_r    <= offset_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_r.found       <= emit_found;
      out_r.match_start <= emit_found ? (pos1 - OB'(n_c)) : '0;
      out_r.match_end   <= emit_found ? pos1 : '0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

[rtl/bss_checker.sv]
// Port-level checks for the bounded substring search block, bound to the top level.
`default_nettype none
module bss_checker #(
  parameter int PATTERN_MAX = 16
) (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              in_stall,
  input wire logic                              out_valid,
  input wire logic                              out_stall,
  input wire bss_pkg::out_req_t                 out_data
);

  localparam int OB = bss_pkg::OFFSET_BITS;

  logic [OB-1:0] span;
  assign span = out_data.match_end - out_data.match_start;

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result visible right after reset");

  // A result that is held off keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed or vanished");

  // The input side is only held off by a waiting result.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with no blocked result");

  // A not-found result carries zero offsets.
  a_nf_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.found |->
      out_data.match_start == '0 && out_data.match_end == '0)
    else $error("not-found result with nonzero offsets");

  // A match spans between one and PATTERN_MAX bytes.
  a_span: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.found |-> span != '0 && span <= OB'(PATTERN_MAX))
    else $error("match span out of range");

endmodule

bind bounded_substring_search_top bss_checker #(.PATTERN_MAX(PATTERN_MAX)) u_bss_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
`default_nettype wire

[tb/bounded_substring_search_top_tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the bounded substring search block, with a built-in search predictor.
module bounded_substring_search_top_tb;

  localparam logic [bss_pkg::CFG_IDX_BITS-1:0] REG_SPARE = 3'd7;

  typedef struct {
    bit                                is_reg;
    logic [bss_pkg::CFG_IDX_BITS-1:0]  idx;
    logic [bss_pkg::CFG_DATA_BITS-1:0] wdata;
    bss_pkg::in_req_t                  req;
    bit                                pinned;
    bit                                fires;
    bss_pkg::out_req_t                 res;
  } plan_row_t;

  logic                              clk = 1'b0;
  logic                              rst_n = 1'b0;
  logic                              in_valid = 1'b0;
  logic                              in_stall;
  bss_pkg::in_req_t                  in_data = '0;
  logic                              out_valid;
  logic                              out_stall = 1'b0;
  bss_pkg::out_req_t                 out_data;
  logic                              cfg_we = 1'b0;
  logic [bss_pkg::CFG_IDX_BITS-1:0]  cfg_index = '0;
  logic [bss_pkg::CFG_DATA_BITS-1:0] cfg_wdata = '0;

  // Hand-typed expectation that travels along with a directed request.
  logic              pin_on = 1'b0;
  logic              pin_fires = 1'b0;
  bss_pkg::out_req_t pin_res = '0;

  // Shadow of the configuration registers.
  logic [63:0] pat_lo, pat_hi;
  logic [4:0]  plen;
  logic        lim_en;
  logic [23:0] lim;

  // Shadow of the search state.
  logic [7:0]  hist [bss_pkg::PAT_BYTES];
  logic [23:0] offs;
  int          fill;
  bit          active;

  bss_pkg::out_req_t match_reports [$];
  plan_row_t         plan [$];
  int                mismatches = 0;
  int                scanned_bytes = 0;
  int                stall_left = 0;
  bit                calm = 0;
  bit                cfg_active = 0;

  bounded_substring_search_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  function automatic logic [7:0] pat_byte(input int i);
    if (i < 8) return pat_lo[8*i +: 8];
    if (i < 16) return pat_hi[8*(i-8) +: 8];
    return 8'h00;
  endfunction

  function automatic int eff_len();
    int n;
    n = plen;
    if (n == 0) n = 1;
    if (n > bss_pkg::PAT_BYTES) n = bss_pkg::PAT_BYTES;
    return n;
  endfunction

  function automatic void scan_byte(input bss_pkg::in_req_t r, output bit fires,
                                    output bss_pkg::out_req_t res);
    logic [23:0] pos;
    int          n;
    bit          hit;
    fires = 0;
    res = '0;
    if (r.restart) begin
      foreach (hist[i]) hist[i] = 8'h00;
      offs = '0;
      fill = 0;
      active = 1;
    end
    if (!active) return;
    pos = offs;
    if (lim_en && pos >= lim) begin
      fires = 1;
      active = 0;
      return;
    end
    for (int i = bss_pkg::PAT_BYTES - 1; i > 0; i--) hist[i] = hist[i-1];
    hist[0] = r.text_byte;
    if (fill < bss_pkg::PAT_BYTES) fill++;
    offs = pos + 24'd1;
    n = eff_len();
    hit = fill >= n;
    for (int i = 0; i < n; i++) begin
      if (hist[n-1-i] != pat_byte(i)) hit = 0;
    end
    if (hit) begin
      fires = 1;
      res.found = 1'b1;
      res.match_start = pos + 24'd1 - 24'(n);
      res.match_end = pos + 24'd1;
      active = 0;
    // The window end is compared without wrapping the offset.
    end else if (r.last_byte || (lim_en && ({1'b0, pos} + 25'd1) >= {1'b0, lim})) begin
      fires = 1;
      active = 0;
    end
  endfunction

  task automatic check_field(input string name, input logic [23:0] want, input logic [23:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  // Receiver: random stall bursts, none once the run has gone calm.
  always @(posedge clk) begin
    if (!rst_n || calm) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 3);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Scoreboard: results are checked before the request taken at the same edge is predicted.
  always @(posedge clk) begin : scoreboard
    bit                fires;
    bss_pkg::out_req_t guess, want;
    if (!rst_n) begin
      pat_lo = '0;
      pat_hi = '0;
      plen = 5'd1;
      lim_en = 1'b0;
      lim = '0;
      foreach (hist[i]) hist[i] = 8'h00;
      offs = '0;
      fill = 0;
      active = 0;
      match_reports.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (match_reports.size() == 0) begin
          $error("unexpected result: found %0d, start %0h, end %0h",
                 out_data.found, out_data.match_start, out_data.match_end);
          mismatches++;
        end else begin
          want = match_reports.pop_front();
          check_field("found", 24'(want.found), 24'(out_data.found));
          check_field("match_start", want.match_start, out_data.match_start);
          check_field("match_end", want.match_end, out_data.match_end);
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          bss_pkg::REG_PATTERN_LOW:    pat_lo = cfg_wdata;
          bss_pkg::REG_PATTERN_HIGH:   pat_hi = cfg_wdata;
          bss_pkg::REG_PATTERN_LENGTH: plen = cfg_wdata[bss_pkg::PLEN_BITS-1:0];
          bss_pkg::REG_LIMIT_ENABLED:  lim_en = cfg_wdata[0];
          bss_pkg::REG_SEARCH_LIMIT:   lim = cfg_wdata[bss_pkg::LIMIT_BITS-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        scan_byte(in_data, fires, guess);
        scanned_bytes++;
        if (pin_on) begin
          fires = pin_fires;
          guess = pin_res;
        end
        if (fires) match_reports.push_back(guess);
      end
    end
  end

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (match_reports.size() != 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic program_reg(input logic [bss_pkg::CFG_IDX_BITS-1:0] idx,
                             input logic [bss_pkg::CFG_DATA_BITS-1:0] data);
    if (!cfg_active) drain_results();
    cfg_active = 1;
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  task automatic send_item(input bss_pkg::in_req_t r, input bit pinned, input bit fires,
                           input bss_pkg::out_req_t res);
    int gap;
    if (cfg_active) begin
      cfg_we <= 1'b0;
      cfg_active = 0;
    end
    if (!calm && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 4);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= r;
    pin_on <= pinned;
    pin_fires <= fires;
    pin_res <= res;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic reg_row(input logic [bss_pkg::CFG_IDX_BITS-1:0] idx,
                         input logic [bss_pkg::CFG_DATA_BITS-1:0] data);
    plan_row_t row;
    row = '{default: '0};
    row.is_reg = 1;
    row.idx = idx;
    row.wdata = data;
    plan.push_back(row);
  endtask

  task automatic byte_row(input logic [7:0] b, input bit rs, input bit lb, input bit pinned,
                          input bit fires, input bit found, input logic [23:0] ms,
                          input logic [23:0] me);
    plan_row_t row;
    row = '{default: '0};
    row.req.text_byte = b;
    row.req.restart = rs;
    row.req.last_byte = lb;
    row.pinned = pinned;
    row.fires = fires;
    row.res.found = found;
    row.res.match_start = ms;
    row.res.match_end = me;
    plan.push_back(row);
  endtask

  function automatic logic [63:0] pick_word();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic reshape_search();
    int v;
    if ($urandom_range(0, 1)) program_reg(bss_pkg::REG_PATTERN_LOW, pick_word());
    if ($urandom_range(0, 1)) program_reg(bss_pkg::REG_PATTERN_HIGH, pick_word());
    case ($urandom_range(0, 9))
      0: v = 0;
      1: v = 31;
      2: v = 16;
      3: v = 17;
      4, 5: v = $urandom_range(5, 15);
      default: v = $urandom_range(1, 4);
    endcase
    program_reg(bss_pkg::REG_PATTERN_LENGTH, 64'(v));
    if ($urandom_range(0, 1)) begin
      program_reg(bss_pkg::REG_LIMIT_ENABLED, 64'($urandom_range(0, 1)));
    end
    if ($urandom_range(0, 1)) begin
      case ($urandom_range(0, 6))
        0: v = 0;
        1: v = 1;
        2: v = 24'hFFFFFF;
        3: v = $urandom & 24'hFFFFFF;
        default: v = $urandom_range(2, 30);
      endcase
      program_reg(bss_pkg::REG_SEARCH_LIMIT, 64'(v));
    end
    if ($urandom_range(0, 5) == 0) program_reg(REG_SPARE - 3'($urandom_range(0, 2)), pick_word());
  endtask

  // One well-formed search: restart on the first byte, often with the pattern planted inside.
  task automatic run_search();
    logic [7:0]       txt [48];
    bss_pkg::in_req_t r;
    int               n, total, at;
    bit               end_mark;
    n = eff_len();
    total = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 48) : $urandom_range(1, 20);
    for (int i = 0; i < total; i++) begin
      txt[i] = $urandom_range(0, 1) ? pat_byte($urandom_range(0, n - 1)) : 8'($urandom);
    end
    if (total >= n && $urandom_range(0, 1)) begin
      at = $urandom_range(0, total - n);
      for (int j = 0; j < n; j++) txt[at + j] = pat_byte(j);
    end
    end_mark = $urandom_range(0, 3) != 0;
    for (int i = 0; i < total; i++) begin
      r.text_byte = txt[i];
      r.restart = (i == 0);
      r.last_byte = end_mark && (i == total - 1);
      send_item(r, 0, 0, '0);
    end
  endtask

  initial begin
    bss_pkg::in_req_t r;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Defaults after reset: pattern byte zero, length one, no limit.
    byte_row(8'hFF, 0, 0, 1, 0, 0, 0, 0);
    byte_row(8'h00, 1, 0, 1, 1, 1, 0, 1);
    byte_row(8'h00, 0, 1, 1, 0, 0, 0, 0);
    reg_row(bss_pkg::REG_PATTERN_LOW, 64'h0807_0605_0403_02A5);
    reg_row(bss_pkg::REG_PATTERN_LENGTH, 64'd0);
    byte_row(8'hA5, 1, 1, 1, 1, 1, 0, 1);
    reg_row(bss_pkg::REG_PATTERN_LENGTH, 64'd2);
    reg_row(REG_SPARE, '1);
    byte_row(8'hA5, 1, 0, 0, 0, 0, 0, 0);
    byte_row(8'hA5, 1, 0, 1, 0, 0, 0, 0);
    byte_row(8'h02, 0, 0, 1, 1, 1, 0, 2);
    byte_row(8'h33, 1, 1, 1, 1, 0, 0, 0);
    reg_row(bss_pkg::REG_LIMIT_ENABLED, 64'd1);
    reg_row(bss_pkg::REG_SEARCH_LIMIT, 64'd0);
    byte_row(8'hA5, 1, 0, 1, 1, 0, 0, 0);
    reg_row(bss_pkg::REG_SEARCH_LIMIT, 64'd2);
    byte_row(8'h11, 1, 0, 0, 0, 0, 0, 0);
    byte_row(8'hA5, 0, 0, 1, 1, 0, 0, 0);
    reg_row(bss_pkg::REG_SEARCH_LIMIT, 64'hFF_FFFF);
    reg_row(bss_pkg::REG_PATTERN_LOW, '1);
    reg_row(bss_pkg::REG_PATTERN_HIGH, '1);
    reg_row(bss_pkg::REG_PATTERN_LENGTH, '1);
    for (int i = 0; i < 16; i++) byte_row(8'hFF, i == 0, i == 15, 0, 0, 0, 0, 0);

    foreach (plan[k]) begin
      if (plan[k].is_reg) program_reg(plan[k].idx, plan[k].wdata);
      else send_item(plan[k].req, plan[k].pinned, plan[k].fires, plan[k].res);
    end

    while (scanned_bytes < 400) begin
      calm = scanned_bytes >= 340;
      reshape_search();
      repeat ($urandom_range(2, 6)) begin
        if ($urandom_range(0, 4) == 0) begin
          repeat ($urandom_range(1, 6)) begin
            r.text_byte = 8'($urandom);
            r.restart = $urandom_range(0, 5) == 0;
            r.last_byte = $urandom_range(0, 3) == 0;
            send_item(r, 0, 0, '0);
          end
        end else begin
          run_search();
        end
      end
    end

    drain_results();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("bounded_substring_search_top_tb: clean");
    end else begin
      $display("bounded_substring_search_top_tb: errors");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("bounded_substring_search_top_tb: errors");
    $finish;
  end

endmodule

[files.f]
rtl/bss_pkg.sv
rtl/bss_cell.sv
rtl/bounded_substring_search_top.sv
rtl/bss_checker.sv
tb/bounded_substring_search_top_tb.sv
